// ===== design/mtd_pkg.sv =====
// Package for the Morse timing decoder: widths, register indexes, letter table.
// No dependencies; imported by morse_timing_decoder_unit.
package mtd_pkg;

  // mark and gap counter width
  localparam int COUNT_WIDTH = 16;
  // width that holds any doubled or tripled threshold without overflow
  localparam int CMP_WIDTH = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 3;

  localparam int CUTOFF_WIDTH = 10;
  localparam int TICKS_WIDTH  = 16;
  localparam int SAMPLE_WIDTH = 10;
  localparam int LETTER_WIDTH = 7;
  localparam int TOTAL_WIDTH  = 3;
  localparam int BITS_WIDTH   = 4;
  localparam int INDEX_WIDTH  = 2;

  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [CMP_WIDTH-1:0]    cmp_t;
  typedef logic [LETTER_WIDTH-1:0] letter_t;
  typedef logic [TOTAL_WIDTH-1:0]  total_t;
  typedef logic [BITS_WIDTH-1:0]   bits_t;
  typedef logic [INDEX_WIDTH-1:0]  index_t;

  localparam count_t COUNT_MAX = '1;

  // configuration register indexes
  localparam index_t REG_LEVEL_CUTOFF = 2'd0;
  localparam index_t REG_DOT_TICKS    = 2'd1;
  localparam index_t REG_DASH_TICKS   = 2'd2;
  localparam index_t REG_PAUSE_TICKS  = 2'd3;

  // register reset values
  localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = 10'd100;
  localparam logic [TICKS_WIDTH-1:0]  DOT_RESET    = 16'd100;
  localparam logic [TICKS_WIDTH-1:0]  DASH_RESET   = 16'd200;
  localparam logic [TICKS_WIDTH-1:0]  PAUSE_RESET  = 16'd100;

  localparam total_t  TOTAL_SAT      = 3'd5;
  localparam letter_t UNKNOWN_LETTER = 7'd45;
  localparam letter_t NO_LETTER      = 7'd0;

  // letter for an element count and pattern, zero when not in the table
  function automatic letter_t lookup_letter(input total_t count, input bits_t bits);
    letter_t c;
    c = NO_LETTER;
    unique case (count)
      3'd1: c = bits[0] ? letter_t'("T") : letter_t'("E");
      3'd2: begin
        unique case (bits[1:0])
          2'd0: c = letter_t'("I");
          2'd1: c = letter_t'("A");
          2'd2: c = letter_t'("N");
          default: c = letter_t'("M");
        endcase
      end
      3'd3: begin
        unique case (bits[2:0])
          3'd0: c = letter_t'("S");
          3'd1: c = letter_t'("U");
          3'd2: c = letter_t'("R");
          3'd3: c = letter_t'("W");
          3'd4: c = letter_t'("D");
          3'd5: c = letter_t'("K");
          3'd6: c = letter_t'("G");
          default: c = letter_t'("O");
        endcase
      end
      3'd4: begin
        unique case (bits)
          4'd0:  c = letter_t'("H");
          4'd1:  c = letter_t'("V");
          4'd2:  c = letter_t'("F");
          4'd4:  c = letter_t'("L");
          4'd6:  c = letter_t'("P");
          4'd7:  c = letter_t'("J");
          4'd8:  c = letter_t'("B");
          4'd9:  c = letter_t'("X");
          4'd10: c = letter_t'("C");
          4'd11: c = letter_t'("Y");
          4'd12: c = letter_t'("Z");
          4'd13: c = letter_t'("Q");
          default: c = NO_LETTER;
        endcase
      end
      default: c = NO_LETTER;
    endcase
    return c;
  endfunction

endpackage

// ===== design/morse_timing_decoder_unit.sv =====
// Morse timing decoder: input register, one-pass decode logic, result register.
// Depends on mtd_pkg.
// An accepted item is held in the input register, where the decode logic works on
// it; its letter, if any, is written to the result register when the item advances.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset (rst, synchronous): registers to their defaults, key up, counters and
// pattern cleared, both stages empty.
module morse_timing_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  mtd_pkg::index_t                   cfg_index,
  input  logic [mtd_pkg::TICKS_WIDTH-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mtd_pkg::SAMPLE_WIDTH-1:0]  sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mtd_pkg::letter_t                  letter,
  output mtd_pkg::total_t                   element_count,
  output mtd_pkg::bits_t                    pattern,
  output logic                              recognized
);
  import mtd_pkg::*;

  // configuration registers
  logic [CUTOFF_WIDTH-1:0] level_cutoff;
  logic [TICKS_WIDTH-1:0]  dot_ticks;
  logic [TICKS_WIDTH-1:0]  dash_ticks;
  logic [TICKS_WIDTH-1:0]  pause_ticks;

  // decoder state
  logic   key_down, key_down_next;
  count_t mark_length, mark_length_next;
  count_t gap_length, gap_length_next;
  bits_t  element_bits, element_bits_next;
  total_t element_total, element_total_next;

  // input register
  logic                    in_q_valid;
  logic [SAMPLE_WIDTH-1:0] sample_q;

  logic advance;
  logic emit;
  cmp_t half_dot, mid_point, mark_ext, gap_twice, pause_triple;
  letter_t table_letter;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_cutoff <= CUTOFF_RESET;
      dot_ticks    <= DOT_RESET;
      dash_ticks   <= DASH_RESET;
      pause_ticks  <= PAUSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_CUTOFF: level_cutoff <= cfg_data[CUTOFF_WIDTH-1:0];
        REG_DOT_TICKS:    dot_ticks    <= cfg_data;
        REG_DASH_TICKS:   dash_ticks   <= cfg_data;
        REG_PAUSE_TICKS:  pause_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q <= sample;
    end
  end

  // thresholds
  assign half_dot     = cmp_t'(dot_ticks) >> 1;
  assign mid_point    = (cmp_t'(dot_ticks) + cmp_t'(dash_ticks)) >> 1;
  assign mark_ext     = cmp_t'(mark_length);
  assign gap_twice    = cmp_t'(gap_length_next) << 1;
  assign pause_triple = (cmp_t'(pause_ticks) << 1) + cmp_t'(pause_ticks);

  // one tick of mark/gap tracking and element collection
  always_comb begin
    key_down_next      = key_down;
    mark_length_next   = mark_length;
    gap_length_next    = gap_length;
    element_bits_next  = element_bits;
    element_total_next = element_total;
    if (sample_q < level_cutoff) begin
      key_down_next = 1'b1;
      if (!key_down) begin
        mark_length_next = count_t'(1);
        gap_length_next  = '0;
      end else if (mark_length != COUNT_MAX) begin
        mark_length_next = mark_length + count_t'(1);
      end
    end else begin
      key_down_next = 1'b0;
      if (key_down) begin
        // classify the mark that just ended
        if (mark_ext >= half_dot) begin
          element_bits_next = {element_bits[BITS_WIDTH-2:0], (mark_ext >= mid_point)};
          if (element_total != TOTAL_SAT) begin
            element_total_next = element_total + total_t'(1);
          end
        end
        mark_length_next = '0;
        gap_length_next  = count_t'(1);
      end else if (gap_length != COUNT_MAX) begin
        gap_length_next = gap_length + count_t'(1);
      end
    end
  end

  assign emit = (sample_q >= level_cutoff) && (element_total_next != '0)
                && (gap_twice >= pause_triple);
  assign table_letter = lookup_letter(element_total_next, element_bits_next);

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      key_down      <= 1'b0;
      mark_length   <= '0;
      gap_length    <= '0;
      element_bits  <= '0;
      element_total <= '0;
    end else if (advance) begin
      key_down    <= key_down_next;
      mark_length <= mark_length_next;
      gap_length  <= gap_length_next;
      if (emit) begin
        element_bits  <= '0;
        element_total <= '0;
      end else begin
        element_bits  <= element_bits_next;
        element_total <= element_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      letter        <= (table_letter == NO_LETTER) ? UNKNOWN_LETTER : table_letter;
      recognized    <= (table_letter != NO_LETTER);
      element_count <= element_total_next;
      pattern       <= element_bits_next;
    end
  end

`ifndef SYNTHESIS
  // a recognized letter is never the unknown mark
  assert property (@(posedge clk) disable iff (rst)
    out_valid && recognized |-> letter != UNKNOWN_LETTER)
    else $error("recognized result carries unknown letter");

  // a result always has at least one element
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> element_count != '0 && element_count <= TOTAL_SAT)
    else $error("result element count out of range");

  // while the key is down the gap counter stays cleared, and vice versa
  assert property (@(posedge clk) disable iff (rst)
    (!key_down || gap_length == '0) && (key_down || mark_length == '0))
    else $error("mark and gap counters both running");

  // the element total saturates at five
  assert property (@(posedge clk) disable iff (rst)
    element_total <= TOTAL_SAT)
    else $error("element total above saturation");
`endif

endmodule
